@@ src/rotation_matrix_to_quaternion_assert.svh @@
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: assertion macros
// Property wrappers used by the top level for its concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication.
`define RMQ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define RMQ_ASSERT_DELAY(lbl, clk, rst, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ src/rmq_pkg.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Widths, sign-flag indices and the control word passed along the chain.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int RMQ_FRAC_BITS_DEF = 14;
  localparam int RMQ_Q_W           = 16;
  localparam logic [RMQ_Q_W-2:0] RMQ_MAG_MAX = '1;

  // Positions of the off-diagonal sign flags in the control word
  localparam int NEG_D21_12 = 0;  // m21 - m12 < 0
  localparam int NEG_D02_20 = 1;  // m02 - m20 < 0
  localparam int NEG_D10_01 = 2;  // m10 - m01 < 0
  localparam int NEG_S10_01 = 3;  // m10 + m01 < 0
  localparam int NEG_S02_20 = 4;  // m02 + m20 < 0
  localparam int NEG_S21_12 = 5;  // m21 + m12 < 0
  localparam int NEG_N      = 6;

  typedef struct packed {
    logic              valid;
    logic [NEG_N-1:0]  neg;
  } rmq_ctl_t;

  // Width of a signed diagonal sum including the added one
  function automatic int rmq_sum_w(input int fb);
    return ((fb > RMQ_Q_W) ? fb : RMQ_Q_W) + 3;
  endfunction

  // Width of the radicand: clamped sum shifted left by FRAC_BITS-2
  function automatic int rmq_rad_w(input int fb);
    return rmq_sum_w(fb) - 1 + fb - 2;
  endfunction

endpackage

@@ src/rotation_matrix_to_quaternion.sv @@
// Pipeline: entry stage, RW = (XW + 1) / 2 root cells (15 at FRAC_BITS = 14),
//   round stage and output stage; the square-root cell chain is fully pipelined.
// Throughput: one matrix per cycle while busy is low.
// Reset: synchronous; clears every valid flag and holds busy high for the cycle
//   after rst drops. done is a one-cycle strobe and cannot be held off.
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: top level
// Q1.14 rotation matrix in, unit quaternion out, through a chain of root cells.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [RMQ_Q_W-1:0] m00,
  input  logic signed [RMQ_Q_W-1:0] m01,
  input  logic signed [RMQ_Q_W-1:0] m02,
  input  logic signed [RMQ_Q_W-1:0] m10,
  input  logic signed [RMQ_Q_W-1:0] m11,
  input  logic signed [RMQ_Q_W-1:0] m12,
  input  logic signed [RMQ_Q_W-1:0] m20,
  input  logic signed [RMQ_Q_W-1:0] m21,
  input  logic signed [RMQ_Q_W-1:0] m22,
  output logic                      done,
  output logic signed [RMQ_Q_W-1:0] quat_w,
  output logic signed [RMQ_Q_W-1:0] quat_x,
  output logic signed [RMQ_Q_W-1:0] quat_y,
  output logic signed [RMQ_Q_W-1:0] quat_z
);

  localparam int SW  = rmq_sum_w(FRAC_BITS);
  localparam int XW  = rmq_rad_w(FRAC_BITS);
  localparam int RW  = (XW + 1) / 2;
  localparam int LAT = RW + 3;

  logic                       take;
  logic [3:0][SW-2:0]         sum_mag;
  rmq_ctl_t                   ctl_s  [RW+1];
  logic [3:0][XW-1:0]         rem_s  [RW+1];
  logic [3:0][RW-1:0]         root_s [RW+1];
  logic [3:0][RMQ_Q_W-1:0]    quat;

  assign take = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  rmq_entry #(.FRAC_BITS(FRAC_BITS)) u_entry (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .m00     (m00),
    .m01     (m01),
    .m02     (m02),
    .m10     (m10),
    .m11     (m11),
    .m12     (m12),
    .m20     (m20),
    .m21     (m21),
    .m22     (m22),
    .sum_mag (sum_mag),
    .ctl     (ctl_s[0])
  );

  // radicand = clamped sum scaled by 2^(FRAC_BITS-2)
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rem_s[0][l]  = XW'(sum_mag[l]) << (FRAC_BITS - 2);
      root_s[0][l] = '0;
    end
  end

  for (genvar g = 0; g < RW; g++) begin : g_chain
    rmq_sqrt_cell #(.FRAC_BITS(FRAC_BITS), .STEP(g)) u_step (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_s[g]),
      .rem_in   (rem_s[g]),
      .root_in  (root_s[g]),
      .ctl_out  (ctl_s[g+1]),
      .rem_out  (rem_s[g+1]),
      .root_out (root_s[g+1])
    );
  end

  rmq_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_s[RW]),
    .rem_in  (rem_s[RW]),
    .root_in (root_s[RW]),
    .done    (done),
    .quat    (quat)
  );

  assign quat_w = quat[0];
  assign quat_x = quat[1];
  assign quat_y = quat[2];
  assign quat_z = quat[3];

  `RMQ_ASSERT_NEXT(a_busy_clears, clk, rst, !rst, !busy, "busy high outside reset")
  `RMQ_ASSERT_DELAY(a_beat_out, clk, rst, take, LAT, done, "accepted beat not delivered")
  `RMQ_ASSERT_IMPLIES(a_no_ghost, clk, rst, done, $past(take, LAT), "result without input beat")
  `RMQ_ASSERT_IMPLIES(a_lead_pos, clk, rst, done, !(quat_w[RMQ_Q_W-1] && quat_x[RMQ_Q_W-1] && quat_y[RMQ_Q_W-1] && quat_z[RMQ_Q_W-1]), "all components negative")

endmodule

@@ src/rmq_entry.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: entry stage
// Forms the four clamped diagonal sums and the six off-diagonal sign flags.
// ---------------------------------------------------------------------------
module rmq_entry import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     take,
  input  logic signed [RMQ_Q_W-1:0]                m00,
  input  logic signed [RMQ_Q_W-1:0]                m01,
  input  logic signed [RMQ_Q_W-1:0]                m02,
  input  logic signed [RMQ_Q_W-1:0]                m10,
  input  logic signed [RMQ_Q_W-1:0]                m11,
  input  logic signed [RMQ_Q_W-1:0]                m12,
  input  logic signed [RMQ_Q_W-1:0]                m20,
  input  logic signed [RMQ_Q_W-1:0]                m21,
  input  logic signed [RMQ_Q_W-1:0]                m22,
  output logic [3:0][rmq_sum_w(FRAC_BITS)-2:0]     sum_mag,
  output rmq_ctl_t                                 ctl
);

  localparam int SW = rmq_sum_w(FRAC_BITS);

  logic signed [SW-1:0]      a, b, c, one_q;
  logic signed [3:0][SW-1:0] s;
  logic signed [RMQ_Q_W:0]   d21, d02, d10, p10, p02, p21;
  logic [NEG_N-1:0]          neg_next;

  always_comb begin
    a     = SW'(m00);
    b     = SW'(m11);
    c     = SW'(m22);
    one_q = SW'(1) << FRAC_BITS;
    s[0]  =  a + b + c + one_q;
    s[1]  =  a - b - c + one_q;
    s[2]  = -a + b - c + one_q;
    s[3]  = -a - b + c + one_q;

    d21 = (RMQ_Q_W+1)'(m21) - (RMQ_Q_W+1)'(m12);
    d02 = (RMQ_Q_W+1)'(m02) - (RMQ_Q_W+1)'(m20);
    d10 = (RMQ_Q_W+1)'(m10) - (RMQ_Q_W+1)'(m01);
    p10 = (RMQ_Q_W+1)'(m10) + (RMQ_Q_W+1)'(m01);
    p02 = (RMQ_Q_W+1)'(m02) + (RMQ_Q_W+1)'(m20);
    p21 = (RMQ_Q_W+1)'(m21) + (RMQ_Q_W+1)'(m12);

    neg_next             = '0;
    neg_next[NEG_D21_12] = d21[RMQ_Q_W];
    neg_next[NEG_D02_20] = d02[RMQ_Q_W];
    neg_next[NEG_D10_01] = d10[RMQ_Q_W];
    neg_next[NEG_S10_01] = p10[RMQ_Q_W];
    neg_next[NEG_S02_20] = p02[RMQ_Q_W];
    neg_next[NEG_S21_12] = p21[RMQ_Q_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= take;
    end
    ctl.neg <= neg_next;
    // clamp negative sums at zero
    for (int l = 0; l < 4; l++) begin
      sum_mag[l] <= s[l][SW-1] ? '0 : s[l][SW-2:0];
    end
  end

endmodule

@@ src/rmq_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: square-root cell
// One restoring digit step for all four lanes, registered towards the next.
// ---------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  rmq_ctl_t                                       ctl_in,
  input  logic [3:0][rmq_rad_w(FRAC_BITS)-1:0]           rem_in,
  input  logic [3:0][(rmq_rad_w(FRAC_BITS)+1)/2-1:0]     root_in,
  output rmq_ctl_t                                       ctl_out,
  output logic [3:0][rmq_rad_w(FRAC_BITS)-1:0]           rem_out,
  output logic [3:0][(rmq_rad_w(FRAC_BITS)+1)/2-1:0]     root_out
);

  localparam int XW = rmq_rad_w(FRAC_BITS);
  localparam int RW = (XW + 1) / 2;
  localparam int SH = RW - 1 - STEP;
  localparam int CW = 2 * RW + 1;

  logic [3:0][CW-1:0] trial;
  logic [3:0]         fit;
  logic [3:0][XW-1:0] rem_next;
  logic [3:0][RW-1:0] root_next;

  // (r + 2^SH)^2 - r^2 = r * 2^(SH+1) + 2^(2*SH)
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial[l]     = (CW'(root_in[l]) << (SH + 1)) + (CW'(1) << (2 * SH));
      fit[l]       = CW'(rem_in[l]) >= trial[l];
      rem_next[l]  = fit[l] ? XW'(CW'(rem_in[l]) - trial[l]) : rem_in[l];
      root_next[l] = fit[l] ? (root_in[l] | (RW'(1) << SH)) : root_in[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.neg <= ctl_in.neg;
    rem_out     <= rem_next;
    root_out    <= root_next;
  end

endmodule

@@ src/rmq_finish.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: finishing stages
// Rounds the roots, picks the largest component, applies signs, saturates.
// ---------------------------------------------------------------------------
module rmq_finish import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  rmq_ctl_t                                       ctl_in,
  input  logic [3:0][rmq_rad_w(FRAC_BITS)-1:0]           rem_in,
  input  logic [3:0][(rmq_rad_w(FRAC_BITS)+1)/2-1:0]     root_in,
  output logic                                           done,
  output logic [3:0][RMQ_Q_W-1:0]                        quat
);

  localparam int XW = rmq_rad_w(FRAC_BITS);
  localparam int RW = (XW + 1) / 2;
  localparam int MW = RW + 1;
  localparam int EW = (MW > RMQ_Q_W) ? MW : RMQ_Q_W;

  typedef enum logic [1:0] {LEAD_W, LEAD_X, LEAD_Y, LEAD_Z} lead_t;

  rmq_ctl_t                   ctl_r;
  logic [3:0][MW-1:0]         mag;
  lead_t                      lead;
  logic [3:0]                 neg;
  logic [3:0][RMQ_Q_W-2:0]    sat;
  logic [3:0][RMQ_Q_W-1:0]    quat_next;
  logic                       win_w, win_x, win_y;

  function automatic logic [RMQ_Q_W-2:0] sat_bits(input logic [EW-1:0] v);
    return v[RMQ_Q_W-2:0];
  endfunction

  // Round to nearest: bump when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.neg <= ctl_in.neg;
    for (int l = 0; l < 4; l++) begin
      mag[l] <= MW'(root_in[l]) + MW'(rem_in[l] > XW'(root_in[l]));
    end
  end

  always_comb begin
    win_w = (mag[0] >= mag[1]) && (mag[0] >= mag[2]) && (mag[0] >= mag[3]);
    win_x = (mag[1] >= mag[0]) && (mag[1] >= mag[2]) && (mag[1] >= mag[3]);
    win_y = (mag[2] >= mag[0]) && (mag[2] >= mag[1]) && (mag[2] >= mag[3]);
    if (win_w) begin
      lead = LEAD_W;
    end else if (win_x) begin
      lead = LEAD_X;
    end else if (win_y) begin
      lead = LEAD_Y;
    end else begin
      lead = LEAD_Z;
    end

    neg = '0;
    unique case (lead)
      LEAD_W: begin
        neg[1] = ctl_r.neg[NEG_D21_12];
        neg[2] = ctl_r.neg[NEG_D02_20];
        neg[3] = ctl_r.neg[NEG_D10_01];
      end
      LEAD_X: begin
        neg[0] = ctl_r.neg[NEG_D21_12];
        neg[2] = ctl_r.neg[NEG_S10_01];
        neg[3] = ctl_r.neg[NEG_S02_20];
      end
      LEAD_Y: begin
        neg[0] = ctl_r.neg[NEG_D02_20];
        neg[1] = ctl_r.neg[NEG_S10_01];
        neg[3] = ctl_r.neg[NEG_S21_12];
      end
      default: begin
        neg[0] = ctl_r.neg[NEG_D10_01];
        neg[1] = ctl_r.neg[NEG_S02_20];
        neg[2] = ctl_r.neg[NEG_S21_12];
      end
    endcase

    // saturate before the sign goes on
    for (int l = 0; l < 4; l++) begin
      sat[l] = (EW'(mag[l]) > EW'(RMQ_MAG_MAX)) ? RMQ_MAG_MAX
                                                : sat_bits(EW'(mag[l]));
      quat_next[l] = neg[l] ? -{1'b0, sat[l]} : {1'b0, sat[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_r.valid;
    end
    quat <= quat_next;
  end

endmodule
